// ===== rtl/core/wbc_pkg.sv =====
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared widths, codes, types and helpers of the wedge beam centroid.
// ----------------------------------------------------------------------------
package wbc_pkg;

  // Corrected current: (sample - pedestal) * gain, units 2^-14 sample.
  localparam int CW  = 33;
  // Doubled, baseline-subtracted current.
  localparam int VW  = 36;
  // Sum and difference of two currents.
  localparam int SW  = VW + 1;
  // Magnitude of a sum or difference.
  localparam int MW  = VW;
  // Magnitude times ring radius.
  localparam int PW  = MW + 16;
  // Dividend 2a + b, with a = 4 * product.
  localparam int NW  = PW + 4;
  // Divisor 2b.
  localparam int DW  = MW + 1;
  // Quotient bits; anything at or above 2^QB saturates.
  localparam int QB  = 25;
  // Partial remainder width.
  localparam int RW  = DW + QB;
  localparam int DIV_LAT = QB + 1;
  localparam int SQW = 2 * QB;
  localparam int BW  = 19;

  localparam logic [QB-1:0] COORD_LIMIT = QB'(1 << 24);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int IDXW = 4;
  localparam logic [IDXW-1:0] REG_PED_INNER   = 4'd0;
  localparam logic [IDXW-1:0] REG_PED_OUTER   = 4'd1;
  localparam logic [IDXW-1:0] REG_NOISE_INNER = 4'd2;
  localparam logic [IDXW-1:0] REG_NOISE_OUTER = 4'd3;
  localparam logic [IDXW-1:0] REG_GAIN_INNER  = 4'd4;
  localparam logic [IDXW-1:0] REG_GAIN_OUTER  = 4'd5;
  localparam logic [IDXW-1:0] REG_RADII       = 4'd6;
  localparam logic [IDXW-1:0] REG_MAX_RADIUS  = 4'd7;

  localparam logic [63:0] GAIN_RESET  = 64'h4000_4000_4000_4000;
  localparam logic [31:0] RADII_RESET = 32'd189597261;
  localparam logic [15:0] MAXR_RESET  = 16'd2560;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_WEAK  = 2'd1;
  localparam logic [1:0] ST_FAR   = 2'd2;

  typedef struct packed {
    logic [63:0] ped_inner;
    logic [63:0] ped_outer;
    logic [63:0] noise_inner;
    logic [63:0] noise_outer;
    logic [63:0] gain_inner;
    logic [63:0] gain_outer;
    logic [31:0] radii;
    logic [15:0] max_radius;
  } cfg_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [7:0][VW-1:0] v;
    logic               weak_inner;
    logic               weak_outer;
    logic [BW-1:0]      baseline;
  } item_t;

  typedef struct packed {
    logic ready;
    logic empty;
  } qstat_t;

  function automatic logic [15:0] lane16(input logic [63:0] r, input int k);
    return r[16*k +: 16];
  endfunction

endpackage

// ===== rtl/core/wedge_beam_centroid.sv =====
// ----------------------------------------------------------------------------
// wedge_beam_centroid
// Difference-over-sum beam position from eight wedge currents.
// ----------------------------------------------------------------------------
// The block takes one sample of eight currents in every cycle in which busy
// is low, and gives each result for one cycle, with done high; results
// cannot be held off. The four 26-stage divide pipelines form the
// coordinates; the rate is one sample per cycle. The back takes a queued
// sample in every cycle that one is waiting, so the queue between the
// classifying front and the dividing back never fills and busy stays low.
// Configuration writes are taken at once (cfg_ready is always high) and
// should be made while no sample is in flight.
module wedge_beam_centroid import wbc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] inner_x_plus,
  input  logic signed [15:0] inner_x_minus,
  input  logic signed [15:0] inner_y_plus,
  input  logic signed [15:0] inner_y_minus,
  input  logic signed [15:0] outer_x_plus,
  input  logic signed [15:0] outer_x_minus,
  input  logic signed [15:0] outer_y_plus,
  input  logic signed [15:0] outer_y_minus,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDXW-1:0]    cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] inner_x_pos,
  output logic signed [15:0] inner_y_pos,
  output logic [1:0]         inner_status,
  output logic signed [15:0] outer_x_pos,
  output logic signed [15:0] outer_y_pos,
  output logic [1:0]         outer_status,
  output logic signed [BW-1:0] common_baseline
);

  cfg_t               cfg;
  qstat_t             qstat;
  logic               push, rd_valid;
  item_t              wr_item, rd_item;
  logic [7:0][15:0]   samp;
  logic signed [15:0] pos [4];
  logic [1:0]         status [2];
  logic [BW-1:0]      baseline;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ped_inner   <= '0;
      cfg.ped_outer   <= '0;
      cfg.noise_inner <= '0;
      cfg.noise_outer <= '0;
      cfg.gain_inner  <= GAIN_RESET;
      cfg.gain_outer  <= GAIN_RESET;
      cfg.radii       <= RADII_RESET;
      cfg.max_radius  <= MAXR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PED_INNER:   cfg.ped_inner   <= cfg_data;
        REG_PED_OUTER:   cfg.ped_outer   <= cfg_data;
        REG_NOISE_INNER: cfg.noise_inner <= cfg_data;
        REG_NOISE_OUTER: cfg.noise_outer <= cfg_data;
        REG_GAIN_INNER:  cfg.gain_inner  <= cfg_data;
        REG_GAIN_OUTER:  cfg.gain_outer  <= cfg_data;
        REG_RADII:       cfg.radii       <= cfg_data[31:0];
        REG_MAX_RADIUS:  cfg.max_radius  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign samp = {outer_y_minus, outer_y_plus, outer_x_minus, outer_x_plus,
                 inner_y_minus, inner_y_plus, inner_x_minus, inner_x_plus};

  wbc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .samp  (samp),
    .cfg   (cfg),
    .qstat (qstat),
    .busy  (busy),
    .push  (push),
    .item  (wr_item)
  );

  wbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .qstat    (qstat),
    .rd_valid (rd_valid),
    .rd_item  (rd_item)
  );

  wbc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_valid),
    .in_item  (rd_item),
    .cfg      (cfg),
    .done     (done),
    .pos      (pos),
    .status   (status),
    .baseline (baseline)
  );

  assign inner_x_pos     = pos[0];
  assign inner_y_pos     = pos[1];
  assign outer_x_pos     = pos[2];
  assign outer_y_pos     = pos[3];
  assign inner_status    = status[0];
  assign outer_status    = status[1];
  assign common_baseline = baseline;

  a_weak_zero: assert property (@(posedge clk) disable iff (rst)
    done && inner_status == ST_WEAK |-> inner_x_pos == '0 && inner_y_pos == '0)
    else $error("weak inner ring reported a nonzero position");

  a_base_nonpos: assert property (@(posedge clk) disable iff (rst)
    done |-> common_baseline[BW-1] || common_baseline == '0)
    else $error("common baseline is positive");

  a_busy_queue: assert property (@(posedge clk) disable iff (rst)
    busy |-> !qstat.empty)
    else $error("front stalled while the queue was empty");

endmodule

// ===== rtl/core/wbc_front.sv =====
// ----------------------------------------------------------------------------
// wbc_front
// Corrects and scales the eight currents, forms the common baseline and
// classifies each ring as strong enough or too weak.
// ----------------------------------------------------------------------------
module wbc_front import wbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [7:0][15:0] samp,
  input  cfg_t             cfg,
  input  qstat_t           qstat,
  output logic             busy,
  output logic             push,
  output item_t            item
);

  logic en;
  logic s1_valid, s2_valid, s3_valid;

  logic signed [CW-1:0]   c1 [8];
  logic [31:0]            ng1 [4];
  logic signed [CW-1:0]   c2 [8];
  logic [34:0]            thr2 [4];
  logic signed [CW:0]     base2;

  logic signed [CW-1:0]   c1_next [8];
  logic [31:0]            ng1_next [4];
  logic signed [CW:0]     base2_next;
  logic [34:0]            thr_next [4];
  item_t                  item_next;

  assign en   = !(s3_valid && !qstat.ready);
  assign busy = !en;
  assign push = s3_valid && qstat.ready;

  // Stage 1: pedestal and gain.
  always_comb begin
    logic [15:0]        ped;
    logic [15:0]        gn;
    logic signed [16:0] d;
    logic signed [33:0] pr;
    for (int k = 0; k < 8; k++) begin
      ped = (k < 4) ? lane16(cfg.ped_inner, k % 4) : lane16(cfg.ped_outer, k % 4);
      gn  = (k < 4) ? lane16(cfg.gain_inner, k % 4) : lane16(cfg.gain_outer, k % 4);
      d   = $signed({samp[k][15], samp[k]}) - $signed({ped[15], ped});
      pr  = d * $signed({1'b0, gn});
      c1_next[k] = pr[CW-1:0];
    end
    // Noise times gain for the plus channels: inner x, inner y, outer x, outer y.
    ng1_next[0] = lane16(cfg.noise_inner, 0) * lane16(cfg.gain_inner, 0);
    ng1_next[1] = lane16(cfg.noise_inner, 2) * lane16(cfg.gain_inner, 2);
    ng1_next[2] = lane16(cfg.noise_outer, 0) * lane16(cfg.gain_outer, 0);
    ng1_next[3] = lane16(cfg.noise_outer, 2) * lane16(cfg.gain_outer, 2);
  end

  // Stage 2: two lowest outer currents, each clamped at or below zero, and the noise thresholds.
  always_comb begin
    logic signed [CW-1:0] m0;
    logic signed [CW-1:0] m1;
    m0 = '0;
    m1 = '0;
    for (int k = 4; k < 8; k++) begin
      if (c1[k] < m0) begin
        m1 = m0;
        m0 = c1[k];
      end else if (c1[k] < m1) begin
        m1 = c1[k];
      end
    end
    base2_next = $signed({m0[CW-1], m0}) + $signed({m1[CW-1], m1});
    for (int k = 0; k < 4; k++) begin
      thr_next[k] = {1'b0, ng1[k], 2'b00} + {2'b00, ng1[k], 1'b0};
    end
  end

  // Stage 3: subtract the baseline, test the noise threshold, round baseline.
  always_comb begin
    logic signed [VW-1:0] vk;
    logic [CW:0]          u;
    logic [CW+1:0]        us;
    logic [BW-1:0]        rb;
    for (int k = 0; k < 8; k++) begin
      vk = $signed({{2{c2[k][CW-1]}}, c2[k], 1'b0}) - $signed({{2{base2[CW]}}, base2});
      item_next.v[k] = vk;
    end
    item_next.weak_inner =
      ($signed(item_next.v[0]) < $signed({1'b0, thr2[0]})) ||
      ($signed(item_next.v[2]) < $signed({1'b0, thr2[1]}));
    item_next.weak_outer =
      ($signed(item_next.v[4]) < $signed({1'b0, thr2[2]})) ||
      ($signed(item_next.v[6]) < $signed({1'b0, thr2[3]}));
    u  = ~base2 + 1'b1;
    us = {1'b0, u} + (CW+2)'(16384);
    rb = us[15 +: BW];
    item_next.baseline = ~rb + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= c1_next;
      ng1   <= ng1_next;
      c2    <= c1;
      base2 <= base2_next;
      thr2  <= thr_next;
      item  <= item_next;
    end
  end

endmodule

// ===== rtl/core/wbc_queue.sv =====
// ----------------------------------------------------------------------------
// wbc_queue
// Short queue between the front and the back of the centroid engine.
// ----------------------------------------------------------------------------
module wbc_queue import wbc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  item_t  wr_item,
  output qstat_t qstat,
  output logic   rd_valid,
  output item_t  rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [LW-1:0] level;
  logic          pop;

  // The back takes an item in every cycle that one is waiting.
  assign pop         = (level != '0);
  assign rd_valid    = pop;
  assign rd_item     = mem[rd_ptr];
  assign qstat.empty = (level == '0);
  assign qstat.ready = (level != LW'(DEPTH)) || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      level <= level + LW'(push) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/wbc_div.sv =====
// ----------------------------------------------------------------------------
// wbc_div
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module wbc_div import wbc_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QB-1:0] quot,
  output logic          ovf
);

  logic [RW-1:0] rem_s [QB+1];
  logic [DW-1:0] d_s   [QB+1];
  logic [QB-1:0] q_s   [QB+1];
  logic          ovf_s [QB+1];

  always_ff @(posedge clk) begin
    rem_s[0] <= RW'(n);
    d_s[0]   <= d;
    q_s[0]   <= '0;
    ovf_s[0] <= RW'(n) >= {d, QB'(0)};
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [RW:0] trial;
    assign trial = {1'b0, rem_s[i-1]} - {1'b0, (RW'(d_s[i-1]) << (QB - i))};
    always_ff @(posedge clk) begin
      rem_s[i] <= trial[RW] ? rem_s[i-1] : trial[RW-1:0];
      q_s[i]   <= {q_s[i-1][QB-2:0], ~trial[RW]};
      d_s[i]   <= d_s[i-1];
      ovf_s[i] <= ovf_s[i-1];
    end
  end

  assign quot = q_s[QB];
  assign ovf  = ovf_s[QB];

endmodule

// ===== rtl/core/wbc_back.sv =====
// ----------------------------------------------------------------------------
// wbc_back
// Difference over sum for the four coordinates, radius test, saturation
// and the result register.
// ----------------------------------------------------------------------------
module wbc_back import wbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              in_item,
  input  cfg_t               cfg,
  output logic               done,
  output logic signed [15:0] pos [4],
  output logic [1:0]         status [2],
  output logic [BW-1:0]      baseline
);

  typedef struct packed {
    logic          weak_inner;
    logic          weak_outer;
    logic [BW-1:0] baseline;
    logic [3:0]    neg;
    logic [3:0]    nneg;
    logic [3:0]    bz;
    logic [3:0]    az;
  } side_t;

  // Stage B1: magnitudes and signs.
  logic          b1_valid;
  logic [MW-1:0] b1_mnum [4];
  logic [MW-1:0] b1_mden [4];
  logic [3:0]    b1_neg, b1_nneg;
  logic          b1_weak_in, b1_weak_out;
  logic [BW-1:0] b1_base;

  // Stage B2: magnitude times radius.
  logic          b2_valid;
  logic [PW-1:0] b2_prod [4];
  logic [MW-1:0] b2_mden [4];
  side_t         b2_side;

  logic          dv [DIV_LAT];
  side_t         ds [DIV_LAT];

  logic [QB-1:0] quot [4];
  logic          ovf  [4];

  // Stage after the divider.
  logic          bq_valid;
  logic [QB-1:0] bq_q [4];
  logic [3:0]    bq_sgn;
  side_t         bq_side;

  // Squares and saturation.
  logic               bs_valid;
  logic [SQW-1:0]     bs_sq [4];
  logic signed [15:0] bs_sat [4];
  logic [31:0]        bs_max2;
  side_t              bs_side;

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] num, den;
    logic [SW-1:0]        mn, md;
    for (int c = 0; c < 4; c++) begin
      num = $signed({in_item.v[2*c][VW-1], in_item.v[2*c]})
          - $signed({in_item.v[2*c+1][VW-1], in_item.v[2*c+1]});
      den = $signed({in_item.v[2*c][VW-1], in_item.v[2*c]})
          + $signed({in_item.v[2*c+1][VW-1], in_item.v[2*c+1]});
      mn = num[SW-1] ? -num : num;
      md = den[SW-1] ? -den : den;
      b1_mnum[c] <= mn[MW-1:0];
      b1_mden[c] <= md[MW-1:0];
      b1_neg[c]  <= num[SW-1] ^ den[SW-1];
      b1_nneg[c] <= num[SW-1];
    end
    b1_weak_in  <= in_item.weak_inner;
    b1_weak_out <= in_item.weak_outer;
    b1_base     <= in_item.baseline;
  end

  always_ff @(posedge clk) begin
    logic [15:0] r;
    for (int c = 0; c < 4; c++) begin
      r = (c < 2) ? cfg.radii[15:0] : cfg.radii[31:16];
      b2_prod[c] <= b1_mnum[c] * r;
      b2_mden[c] <= b1_mden[c];
    end
    b2_side.weak_inner <= b1_weak_in;
    b2_side.weak_outer <= b1_weak_out;
    b2_side.baseline   <= b1_base;
    b2_side.neg        <= b1_neg;
    b2_side.nneg       <= b1_nneg;
    for (int c = 0; c < 4; c++) begin
      b2_side.bz[c] <= (b1_mden[c] == '0);
      b2_side.az[c] <= (b1_mnum[c] == '0) || ((c < 2) ? (cfg.radii[15:0] == '0)
                                                     : (cfg.radii[31:16] == '0));
    end
  end

  // Dividend 2a + b with a = 4 * product; divisor 2b.
  for (genvar c = 0; c < 4; c++) begin : g_div
    wbc_div u_div (
      .clk  (clk),
      .n    ({b2_prod[c], 3'b000} + NW'(b2_mden[c])),
      .d    ({b2_mden[c], 1'b0}),
      .quot (quot[c]),
      .ovf  (ovf[c])
    );
  end

  always_ff @(posedge clk) begin
    ds[0] <= b2_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      ds[i] <= ds[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_t s;
    s = ds[DIV_LAT-1];
    for (int c = 0; c < 4; c++) begin
      if (s.bz[c]) begin
        bq_q[c]   <= s.az[c] ? '0 : COORD_LIMIT;
        bq_sgn[c] <= s.nneg[c];
      end else begin
        bq_q[c]   <= (ovf[c] || (quot[c] > COORD_LIMIT)) ? COORD_LIMIT : quot[c];
        bq_sgn[c] <= s.neg[c];
      end
    end
    bq_side <= s;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      bs_sq[c] <= bq_q[c] * bq_q[c];
      if (bq_sgn[c]) begin
        bs_sat[c] <= (bq_q[c] >= QB'(32768)) ? 16'sh8000 : -$signed(bq_q[c][15:0]);
      end else begin
        bs_sat[c] <= (bq_q[c] > QB'(32767)) ? 16'sh7FFF : $signed(bq_q[c][15:0]);
      end
    end
    bs_max2 <= cfg.max_radius * cfg.max_radius;
    bs_side <= bq_side;
  end

  always_ff @(posedge clk) begin
    logic [SQW:0] r2;
    logic         ring_weak;
    for (int g = 0; g < 2; g++) begin
      r2        = {1'b0, bs_sq[2*g]} + {1'b0, bs_sq[2*g+1]};
      ring_weak = (g == 0) ? bs_side.weak_inner : bs_side.weak_outer;
      if (ring_weak) begin
        status[g]    <= ST_WEAK;
        pos[2*g]     <= '0;
        pos[2*g+1]   <= '0;
      end else begin
        status[g]    <= (r2 > (SQW+1)'(bs_max2)) ? ST_FAR : ST_VALID;
        pos[2*g]     <= bs_sat[2*g];
        pos[2*g+1]   <= bs_sat[2*g+1];
      end
    end
    baseline <= bs_side.baseline;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) begin
        dv[i] <= 1'b0;
      end
      bq_valid <= 1'b0;
      bs_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      b1_valid <= in_valid;
      b2_valid <= b1_valid;
      dv[0]    <= b2_valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv[i] <= dv[i-1];
      end
      bq_valid <= dv[DIV_LAT-1];
      bs_valid <= bq_valid;
      done     <= bs_valid;
    end
  end

endmodule
